@@ src/mffp_pkg.sv @@
package mffp_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned IdxW     = 4;

  localparam logic [IdxW-1:0] FirstIdx = IdxW'(0);
  localparam logic [IdxW-1:0] CheckIdx = IdxW'(FrameLen - 1);

  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [7:0] CrcInit = 8'h00;

  localparam logic [7:0] LeftIdReset = 8'h01;

  // Fault byte bit positions
  localparam int unsigned FaultPhaseOcBit = 0;
  localparam int unsigned FaultBusOcBit   = 1;
  localparam int unsigned FaultSensorBit  = 2;
  localparam int unsigned FaultStallBit   = 3;

  // Register map: register index sits above the byte offset
  localparam int unsigned PaddrW = 3;
  localparam logic        RegLeftId = 1'b0;

  typedef struct packed {
    logic [7:0]         mode;
    logic [15:0]        current;
    logic signed [15:0] speed;
    logic [7:0]         temperature;
    logic [7:0]         angle;
    logic [7:0]         fault;
  } mffp_record_t;

  typedef struct packed {
    logic         crc_ok;
    logic         is_left;
    mffp_record_t rec;
  } mffp_result_t;

  // One byte of the reflected CRC-8, LSB first
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/mffp_cfg_regs.sv @@
module mffp_cfg_regs import mffp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [7:0]        left_id_o
);

  logic [7:0] left_id_q, left_id_d;
  logic       reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PaddrW-1];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    left_id_d = left_id_q;
    if (wr_en && (reg_sel == RegLeftId)) begin
      left_id_d = pwdata[7:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegLeftId: prdata = {24'b0, left_id_q};
      default:   prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_id_q <= LeftIdReset;
    end else begin
      left_id_q <= left_id_d;
    end
  end

  assign left_id_o = left_id_q;

endmodule

@@ src/mffp_frame_engine.sv @@
module mffp_frame_engine import mffp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   rx_byte_i,
  input  logic         frame_start_i,
  input  logic [7:0]   requested_id_i,
  input  logic [7:0]   left_id_i,
  output logic         emit_o,
  output mffp_result_t result_o
);

  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      frame_q [8];
  mffp_record_t    left_q, left_d;
  mffp_record_t    right_q, right_d;

  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] idx_m1;
  logic            is_check;
  logic            crc_ok;
  logic            is_left;
  mffp_record_t    rx_rec;
  mffp_record_t    sel_rec;

  always_comb begin
    idx = frame_start_i ? FirstIdx : byte_index_q;
    if (idx > CheckIdx) begin
      idx = FirstIdx;
    end
  end

  assign idx_m1   = idx - IdxW'(1);
  assign is_check = (idx == CheckIdx);
  assign crc_ok   = (rx_byte_i == crc_q);
  assign is_left  = (requested_id_i == left_id_i);

  always_comb begin
    rx_rec.mode        = frame_q[0];
    rx_rec.current     = {frame_q[1], frame_q[2]};
    rx_rec.speed       = {frame_q[3], frame_q[4]};
    rx_rec.temperature = frame_q[5];
    rx_rec.angle       = frame_q[6];
    rx_rec.fault       = frame_q[7];
  end

  always_comb begin
    sel_rec = is_left ? left_q : right_q;
    if (crc_ok) begin
      sel_rec = rx_rec;
    end
  end

  always_comb begin
    byte_index_d = byte_index_q;
    crc_d        = crc_q;
    left_d       = left_q;
    right_d      = right_q;
    if (step_i) begin
      if (is_check) begin
        byte_index_d = FirstIdx;
        crc_d        = CrcInit;
        if (is_left) begin
          left_d = sel_rec;
        end else begin
          right_d = sel_rec;
        end
      end else begin
        byte_index_d = idx + IdxW'(1);
        crc_d        = crc8_step((idx == FirstIdx) ? CrcInit : crc_q, rx_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= FirstIdx;
      crc_q        <= CrcInit;
      left_q       <= '0;
      right_q      <= '0;
    end else begin
      byte_index_q <= byte_index_d;
      crc_q        <= crc_d;
      left_q       <= left_d;
      right_q      <= right_d;
    end
  end

  // Capture payload bytes 1..8; byte 0 and the check byte are not kept
  always_ff @(posedge clk_i) begin
    if (step_i && !is_check && (idx != FirstIdx)) begin
      frame_q[idx_m1[2:0]] <= rx_byte_i;
    end
  end

  assign emit_o           = step_i && is_check;
  assign result_o.crc_ok  = crc_ok;
  assign result_o.is_left = is_left;
  assign result_o.rec     = sel_rec;

endmodule

@@ src/motor_feedback_frame_parser.sv @@
// Motor feedback frame parser: takes a 10-byte feedback reply one byte per
// transaction (frame_start marks byte 0 and restarts the count) and runs a
// reflected CRC-8 (polynomial 0x8C, init 0) over bytes 0 to 8. On the tenth
// byte one result leaves: on a CRC match bytes 1..8 go into the left record
// (requested_id equal to left_id) or the right record; on a mismatch the
// record is kept and reported with crc_ok low. One byte is accepted every
// cycle while the input does not stall; a check byte first sits in the
// input register, and its result is loaded into the result register when
// that byte moves on. The input only stalls when the result register is
// full and not being taken. left_id lives at APB address 0 and resets to 1.
module motor_feedback_frame_parser import mffp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  input  logic [7:0]         requested_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               crc_ok_o,
  output logic               is_left_o,
  output logic [7:0]         motor_mode_o,
  output logic [15:0]        motor_current_o,
  output logic signed [15:0] motor_speed_o,
  output logic [7:0]         temperature_o,
  output logic [7:0]         angle_o,
  output logic [7:0]         fault_byte_o,
  output logic               phase_overcurrent_o,
  output logic               bus_overcurrent_o,
  output logic               sensor_fault_o,
  output logic               stalled_o
);

  logic [7:0]   left_id;
  logic         in_valid_q, in_valid_d;
  logic [7:0]   rx_byte_q;
  logic         frame_start_q;
  logic [7:0]   requested_id_q;
  logic         out_valid_q, out_valid_d;
  mffp_result_t res_q;
  mffp_result_t res;
  logic         emit;
  logic         advance;
  logic         in_fire;

  mffp_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .left_id_o (left_id)
  );

  // Stage 1 moves on whenever the result register has room
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  mffp_frame_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .rx_byte_i      (rx_byte_q),
    .frame_start_i  (frame_start_q),
    .requested_id_i (requested_id_q),
    .left_id_i      (left_id),
    .emit_o         (emit),
    .result_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rx_byte_q      <= rx_byte_i;
      frame_start_q  <= frame_start_i;
      requested_id_q <= requested_id_i;
    end
  end

  // Hold the result until the transaction completes downstream
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign crc_ok_o            = res_q.crc_ok;
  assign is_left_o           = res_q.is_left;
  assign motor_mode_o        = res_q.rec.mode;
  assign motor_current_o     = res_q.rec.current;
  assign motor_speed_o       = res_q.rec.speed;
  assign temperature_o       = res_q.rec.temperature;
  assign angle_o             = res_q.rec.angle;
  assign fault_byte_o        = res_q.rec.fault;
  assign phase_overcurrent_o = res_q.rec.fault[FaultPhaseOcBit];
  assign bus_overcurrent_o   = res_q.rec.fault[FaultBusOcBit];
  assign sensor_fault_o      = res_q.rec.fault[FaultSensorBit];
  assign stalled_o           = res_q.rec.fault[FaultStallBit];

endmodule
